// ===== src/swmc_pkg.sv =====
// Shared types and constants for the stack with max and count queries.
`default_nettype none

package swmc_pkg;

  // Stack geometry.
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths.
  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 7;

  // Largest value the match count field can show.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Request opcodes.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_TOP   = 3'd2,
    OP_MAX   = 3'd3,
    OP_COUNT = 3'd4,
    OP_CLEAR = 3'd5
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // latch the request word
    logic exec;     // update the stack and set up the result
    logic scan_rd;  // read one entry and step the scan pointer
    logic out_ld;   // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_scan;  // request reads stored entries
    logic scan_last;   // scan pointer is at its final entry
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/swmc_dp.sv =====
// Datapath: entry memory, fill level, scan pointer, accumulators and result register.
`default_nettype none

module swmc_dp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire swmc_pkg::ctrl_cmd_t                   cmd_i,
  output swmc_pkg::dp_stat_t                         stat_o,
  input  wire logic [swmc_pkg::OP_W-1:0]             opcode_i,
  input  wire logic signed [swmc_pkg::DATA_W-1:0]    value_i,
  output logic                                       status_o,
  output logic signed [swmc_pkg::DATA_W-1:0]         data_o,
  output logic [swmc_pkg::CNT_W-1:0]                 match_count_o
);

  // Entry storage, slot 0 at the bottom.
  logic [swmc_pkg::DATA_W-1:0] mem [swmc_pkg::DEPTH];

  swmc_pkg::op_e                       op_q;
  logic signed [swmc_pkg::DATA_W-1:0]  key_q;
  logic [swmc_pkg::FILL_W-1:0]         fill_q, fill_d;
  logic [swmc_pkg::FILL_W-1:0]         fill_dec;
  logic                                full, empty;
  logic [swmc_pkg::ADDR_W-1:0]         idx_q, hi_q;
  logic signed [swmc_pkg::DATA_W-1:0]  rd_data_q;
  logic                                rd_vld_q;
  logic                                rd_first_q;
  logic                                res_status_q;
  logic signed [swmc_pkg::DATA_W-1:0]  res_data_q;
  logic [swmc_pkg::CNT_W-1:0]          cnt_q;

  assign full     = (fill_q == swmc_pkg::FILL_W'(swmc_pkg::DEPTH));
  assign empty    = (fill_q == '0);
  assign fill_dec = fill_q - swmc_pkg::FILL_W'(1);

  // Status toward the controller.
  always_comb begin
    stat_o.needs_scan = 1'b0;
    stat_o.scan_last  = (idx_q == hi_q);
    unique case (op_q) inside
      swmc_pkg::OP_TOP, swmc_pkg::OP_MAX, swmc_pkg::OP_COUNT: stat_o.needs_scan = !empty;
      default: stat_o.needs_scan = 1'b0;
    endcase
  end

  // Request word capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= swmc_pkg::op_e'(opcode_i);
      key_q <= value_i;
    end
  end

  // Next fill level for the request being executed.
  always_comb begin
    fill_d = fill_q;
    if (cmd_i.exec) begin
      unique case (op_q)
        swmc_pkg::OP_PUSH:  if (!full)  fill_d = fill_q + swmc_pkg::FILL_W'(1);
        swmc_pkg::OP_POP:   if (!empty) fill_d = fill_dec;
        swmc_pkg::OP_CLEAR: fill_d = '0;
        default:            fill_d = fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Memory write on push and registered read for the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (op_q == swmc_pkg::OP_PUSH) && !full) begin
      mem[fill_q[swmc_pkg::ADDR_W-1:0]] <= key_q;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
    end
  end

  // Scan range: top reads only the last entry, max and count read them all.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      hi_q <= fill_dec[swmc_pkg::ADDR_W-1:0];
      if (op_q == swmc_pkg::OP_TOP) begin
        idx_q <= fill_dec[swmc_pkg::ADDR_W-1:0];
      end else begin
        idx_q <= '0;
      end
    end else if (cmd_i.scan_rd) begin
      idx_q <= idx_q + swmc_pkg::ADDR_W'(1);
    end
  end

  // Result setup and accumulation over the words read back.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_data_q <= '0;
      cnt_q      <= '0;
      rd_first_q <= 1'b1;
      unique case (op_q) inside
        swmc_pkg::OP_PUSH:                  res_status_q <= full;
        swmc_pkg::OP_POP, swmc_pkg::OP_TOP,
        swmc_pkg::OP_MAX:                   res_status_q <= empty;
        swmc_pkg::OP_COUNT,
        swmc_pkg::OP_CLEAR:                 res_status_q <= 1'b0;
        default:                            res_status_q <= 1'b1;
      endcase
    end else if (rd_vld_q) begin
      rd_first_q <= 1'b0;
      if (op_q == swmc_pkg::OP_COUNT) begin
        if ((rd_data_q == key_q) && (cnt_q != swmc_pkg::CNT_MAX)) begin
          cnt_q <= cnt_q + swmc_pkg::CNT_W'(1);
        end
      end else if (rd_first_q || (rd_data_q > res_data_q)) begin
        res_data_q <= rd_data_q;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      status_o      <= res_status_q;
      data_o        <= res_data_q;
      match_count_o <= cnt_q;
    end
  end

endmodule

`default_nettype wire

// ===== src/swmc_ctrl.sv =====
// Controller: request sequencing, scan control and output handshake.
`default_nettype none

module swmc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output swmc_pkg::ctrl_cmd_t       cmd_o,
  input  wire swmc_pkg::dp_stat_t   stat_i
);

  swmc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // The output register can take a word when empty or being drained now.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swmc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      swmc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = swmc_pkg::ST_EXEC;
        end
      end
      swmc_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.needs_scan ? swmc_pkg::ST_SCAN : swmc_pkg::ST_FINISH;
      end
      swmc_pkg::ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = swmc_pkg::ST_DRAIN;
        end
      end
      swmc_pkg::ST_DRAIN: begin
        state_d = swmc_pkg::ST_FINISH;
      end
      swmc_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = swmc_pkg::ST_IDLE;
        end
      end
      default: state_d = swmc_pkg::ST_IDLE;
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== src/stack_with_max_and_count.sv =====
// Top level of the LIFO stack with top, max and count-equal queries.
`default_nettype none

// A bounded LIFO of up to 64 signed 32-bit entries held in one memory with a
// registered read port. Each request word gives one result word. Push, pop,
// clear and unused opcodes go from acceptance through the execute state to
// finish, where the result word is loaded into the output register; top also
// passes through scan and drain to read the last entry. Max and count walk the
// stored entries through the single memory read port, one entry per cycle, in
// the scan state. Top, max and count on an empty stack read nothing and go
// straight from execute to finish. A new request is taken once the previous
// one has reached the output register, even while that result word is still
// stalled. No clearing pass follows reset: the stack is empty at once.
module stack_with_max_and_count (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [swmc_pkg::OP_W-1:0]           opcode_i,
  input  wire logic signed [swmc_pkg::DATA_W-1:0]  value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     status_o,
  output logic signed [swmc_pkg::DATA_W-1:0]       data_o,
  output logic [swmc_pkg::CNT_W-1:0]               match_count_o
);

  swmc_pkg::ctrl_cmd_t cmd;
  swmc_pkg::dp_stat_t  stat;

  // Sequencer.
  swmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Storage and arithmetic.
  swmc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .opcode_i      (opcode_i),
    .value_i       (value_i),
    .status_o      (status_o),
    .data_o        (data_o),
    .match_count_o (match_count_o)
  );

endmodule

`default_nettype wire

// ===== sim/stack_with_max_and_count_tb.sv =====
// Self-checking testbench for the LIFO stack with top, max and count-equal queries.
`default_nettype none

module stack_with_max_and_count_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swmc_pkg::*;

  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned LIMIT_CYCLES = 600_000;
  localparam int unsigned RANDOM_WORDS = 750;
  localparam int unsigned HOLD_CYCLES  = 300;

  // Opcodes the block does not define; they must fail without side effects.
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // One result word as the stack should report it.
  typedef struct {
    logic                     status;
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         hits;
  } answer_t;

  // Mirror of the stack contents and the queue of answers still owed.
  class stack_scoreboard;
    logic signed [DATA_W-1:0] slots [DEPTH];
    int unsigned              level;
    answer_t                  owed_q [$];
    int unsigned              errors;

    function new();
      level  = 0;
      errors = 0;
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction

    // Apply one accepted request to the mirror and queue its answer.
    function void note_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
      answer_t     ans;
      int unsigned i;
      int unsigned n;
      ans.status = 1'b0;
      ans.data   = '0;
      ans.hits   = '0;
      n          = 0;
      case (op)
        OP_PUSH: begin
          if (level >= DEPTH) begin
            ans.status = 1'b1;
          end else begin
            slots[level] = val;
            level++;
          end
        end
        OP_POP: begin
          if (level == 0) ans.status = 1'b1;
          else level--;
        end
        OP_TOP: begin
          if (level == 0) ans.status = 1'b1;
          else ans.data = slots[level-1];
        end
        OP_MAX: begin
          if (level == 0) begin
            ans.status = 1'b1;
          end else begin
            ans.data = slots[level-1];
            for (i = 0; i < level; i++)
              if (slots[i] > ans.data) ans.data = slots[i];
          end
        end
        OP_COUNT: begin
          for (i = 0; i < level; i++)
            if (slots[i] == val) n++;
          ans.hits = (n > CNT_MAX) ? CNT_MAX : n[CNT_W-1:0];
        end
        OP_CLEAR: begin
          level = 0;
        end
        default: begin
          ans.status = 1'b1;
        end
      endcase
      owed_q.push_back(ans);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Compare one accepted result word with the oldest answer owed.
    task check_result(logic st, logic signed [DATA_W-1:0] d, logic [CNT_W-1:0] c);
      answer_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("word with nothing owed: status %0d data %0d count %0d",
                                  st, d, c));
        return;
      end
      want = owed_q.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status expected %0d, got %0d", want.status, st));
      if (d !== want.data)
        report_mismatch($sformatf("data expected %0d, got %0d", want.data, d));
      if (c !== want.hits)
        report_mismatch($sformatf("match count expected %0d, got %0d", want.hits, c));
    endtask
  endclass

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     req_valid = 1'b0;
  logic [OP_W-1:0]          req_op    = '0;
  logic signed [DATA_W-1:0] req_value = '0;
  logic                     rsp_stall = 1'b0;
  logic                     req_stall;
  logic                     rsp_valid;
  logic                     rsp_status;
  logic signed [DATA_W-1:0] rsp_data;
  logic [CNT_W-1:0]         rsp_count;

  // Shared knobs: no_idle turns off random gaps, long_hold asks for a long stall.
  bit no_idle   = 1'b0;
  bit long_hold = 1'b0;

  stack_scoreboard sb = new();

  stack_with_max_and_count dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (req_valid),
    .in_stall_o    (req_stall),
    .opcode_i      (req_op),
    .value_i       (req_value),
    .out_valid_o   (rsp_valid),
    .out_stall_i   (rsp_stall),
    .status_o      (rsp_status),
    .data_o        (rsp_data),
    .match_count_o (rsp_count)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Offer one request word and return once it has been accepted.
  task automatic send_word(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_op    <= op;
    req_value <= val;
    do @(posedge clk); while (req_stall);
    sb.note_request(op, val);
  endtask

  // Hold off the sender until every owed answer has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Values cluster on a few small numbers so that count finds matches.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      v = $urandom_range(0, 6);
      return v - 3;
    end
    if (r < 8) return $urandom;
    if (r == 8) return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    return $urandom_range(0, 1) ? VAL_MAX - $urandom_range(0, 2) : VAL_MIN + $urandom_range(0, 2);
  endfunction

  // Choose an opcode; push_pct steers the fill level up or down.
  function automatic logic [OP_W-1:0] pick_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return OP_PUSH;
    r = $urandom_range(0, 99);
    if (r < 30) return OP_POP;
    if (r < 48) return OP_TOP;
    if (r < 68) return OP_MAX;
    if (r < 90) return OP_COUNT;
    if (r < 95) return OP_CLEAR;
    return $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
  endfunction

  // Result side: random stalls, one long hold on request, check every word taken.
  initial begin
    int unsigned gap;
    wait (rst_n);
    forever begin
      if (long_hold) gap = HOLD_CYCLES;
      else gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        rsp_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        long_hold = 1'b0;
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
      sb.check_result(rsp_status, rsp_data, rsp_count);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned seg_len;
    int unsigned push_pct;
    int unsigned i;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty stack, spare opcodes, extreme values, and clear.
    send_word(OP_TOP, $urandom);
    send_word(OP_POP, $urandom);
    send_word(OP_MAX, $urandom);
    send_word(OP_COUNT, 32'sd0);
    send_word(OP_SPARE6, $urandom);
    send_word(OP_SPARE7, $urandom);
    send_word(OP_PUSH, VAL_MIN);
    send_word(OP_MAX, $urandom);
    send_word(OP_PUSH, VAL_MAX);
    send_word(OP_PUSH, 32'sd0);
    send_word(OP_PUSH, -32'sd1);
    send_word(OP_PUSH, VAL_MIN);
    send_word(OP_TOP, $urandom);
    send_word(OP_MAX, $urandom);
    send_word(OP_COUNT, VAL_MIN);
    send_word(OP_COUNT, -32'sd1);
    send_word(OP_COUNT, 32'sd1234);
    send_word(OP_POP, $urandom);
    send_word(OP_TOP, $urandom);
    send_word(OP_POP, $urandom);
    send_word(OP_POP, $urandom);
    send_word(OP_MAX, $urandom);
    send_word(OP_CLEAR, $urandom);
    send_word(OP_TOP, $urandom);
    send_word(OP_POP, $urandom);
    wait_drained();

    // Fill to the brim with one value, overflow, count it all, clear, then push and query again.
    for (i = 0; i < DEPTH; i++) send_word(OP_PUSH, 32'sd5);
    send_word(OP_PUSH, 32'sd9);
    send_word(OP_COUNT, 32'sd5);
    send_word(OP_MAX, $urandom);
    send_word(OP_TOP, $urandom);
    send_word(OP_CLEAR, $urandom);
    send_word(OP_COUNT, 32'sd5);
    send_word(OP_PUSH, -32'sd9);
    send_word(OP_TOP, $urandom);
    send_word(OP_MAX, $urandom);
    send_word(OP_COUNT, 32'sd5);

    // Long result stall while requests keep coming, so the input backs up.
    long_hold = 1'b1;
    no_idle   = 1'b1;
    for (i = 0; i < 30; i++) send_word(pick_op(70), pick_value());
    no_idle = 1'b0;
    wait_drained();

    // Random segments, each steering the fill level one way.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      seg_len = $urandom_range(30, 90);
      case ($urandom_range(0, 3))
        0: push_pct = 92;
        1: push_pct = 50;
        2: push_pct = 15;
        default: push_pct = 55;
      endcase
      no_idle = (push_pct == 55);
      for (i = 0; i < seg_len; i++) send_word(pick_op(push_pct), pick_value());
      sent += seg_len;
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    no_idle = 1'b0;

    // Let the last answers arrive, then a margin for a stray word.
    wait_drained();
    repeat (DEPTH + 16) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
